// ----- rtl/isfm_pkg.sv -----
// Package for the input source freshness merger.
// Holds slot count, action and register codes and the request/response payload structs.
// No dependencies.
package isfm_pkg;

   // number of source slots (1..16)
   localparam int SOURCES = 4;
   localparam int SLOT_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;

   // action codes
   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK   = 2'd1;

   localparam logic [15:0] HOLD_TICKS_RESET = 16'd3000;
   localparam logic [1:0]  FALLBACK_RESET   = 2'd0;

   // clamp limits
   localparam logic signed [15:0] STEER_MIN = -16'sd1000;
   localparam logic signed [15:0] STEER_MAX = 16'sd1000;
   localparam logic signed [15:0] PEDAL_MIN = 16'sd0;
   localparam logic signed [15:0] PEDAL_MAX = 16'sd1000;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         source;
      logic signed [15:0] steer_in;
      logic signed [15:0] throttle_in;
      logic signed [15:0] brake_in;
      logic [31:0]        button_bits;
   } req_type;

   typedef struct packed {
      logic signed [10:0] steer_out;
      logic [9:0]         throttle_out;
      logic [9:0]         brake_out;
      logic [31:0]        merged_buttons;
      logic               any_fresh;
   } rsp_type;

endpackage

// ----- rtl/input_source_freshness_merger_core.sv -----
// Top level of the input source freshness merger.
// Slot storage, scan sequencer and response register; uses isfm_pkg.
//
// Several control sources push clamped steering (-1000..1000), throttle and brake
// (0..1000) and a button word into their own slot; a push naming a source outside
// the slot range goes to the fallback slot (slot 0 if that is out of range too).
// A tick ages every slot, saturating at hold_ticks. A read returns the analog
// values of the most recently pushed slot while it is fresh (seen and age below
// hold_ticks) together with the OR of the buttons of all fresh slots; otherwise
// all zeros with any_fresh low. Only reads produce a response transfer.
// Sequencing: a push or unused action is done in idle. A tick walks the slots in the
// tick state; a read walks them in the read state, then waits in the done state while
// the previous response sits stalled in the output register. Both walk the slots one per
// cycle through a single age comparator and incrementer; req_stall is high for the
// whole walk. Configuration writes are always taken (csr_ready is tied high).
module input_source_freshness_merger_core
   import isfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SOURCES - 1);

   function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
      logic signed [15:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // configuration
   logic [15:0] hold_ff, hold_in;
   logic [1:0]  fallback_ff, fallback_in;

   // slot storage: payload fields have no reset, age and seen do
   logic signed [10:0] slot_steer_ff    [SOURCES];
   logic [9:0]         slot_throttle_ff [SOURCES];
   logic [9:0]         slot_brake_ff    [SOURCES];
   logic [31:0]        slot_buttons_ff  [SOURCES];
   logic [15:0]        slot_age_ff      [SOURCES];
   logic [15:0]        slot_age_in      [SOURCES];
   logic [SOURCES-1:0] slot_seen_ff, slot_seen_in;
   logic [SLOT_W-1:0]  latest_ff, latest_in;

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   // read accumulation
   logic               win_fresh_ff, win_fresh_in;
   logic [31:0]        buttons_ff, buttons_in;
   logic signed [10:0] win_steer_ff, win_steer_in;
   logic [9:0]         win_throttle_ff, win_throttle_in;
   logic [9:0]         win_brake_ff, win_brake_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              req_xfer, csr_xfer, push_xfer;
   logic              src_ok, fb_ok;
   logic [SLOT_W-1:0] push_slot;
   logic signed [15:0] steer_c, throttle_c, brake_c;

   // shared unit: one age compare and one increment at the scan index
   logic        age_below;
   logic        fresh_now;
   logic [15:0] age_inc;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign push_xfer = req_xfer && (req_data.action == ACT_PUSH);
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   assign src_ok    = ({1'b0, req_data.source} < 5'(SOURCES));
   assign fb_ok     = ({3'b000, fallback_ff} < 5'(SOURCES));
   assign push_slot = src_ok ? SLOT_W'(req_data.source)
                    : (fb_ok ? SLOT_W'(fallback_ff) : '0);

   assign steer_c    = clamp16(req_data.steer_in, STEER_MIN, STEER_MAX);
   assign throttle_c = clamp16(req_data.throttle_in, PEDAL_MIN, PEDAL_MAX);
   assign brake_c    = clamp16(req_data.brake_in, PEDAL_MIN, PEDAL_MAX);

   assign age_below = (slot_age_ff[idx_ff] < hold_ff);
   assign age_inc   = slot_age_ff[idx_ff] + 16'd1;
   assign fresh_now = slot_seen_ff[idx_ff] && age_below;

   always_comb begin
      hold_in         = hold_ff;
      fallback_in     = fallback_ff;
      slot_age_in     = slot_age_ff;
      slot_seen_in    = slot_seen_ff;
      latest_in       = latest_ff;
      state_in        = state_ff;
      idx_in          = idx_ff;
      win_fresh_in    = win_fresh_ff;
      buttons_in      = buttons_ff;
      win_steer_in    = win_steer_ff;
      win_throttle_in = win_throttle_ff;
      win_brake_in    = win_brake_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_xfer) begin
         case (csr_index)
            CSR_HOLD_TICKS: hold_in = csr_data;
            CSR_FALLBACK:   fallback_in = csr_data[1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in = '0;
               case (req_data.action)
                  ACT_PUSH: begin
                     slot_age_in[push_slot]  = '0;
                     slot_seen_in[push_slot] = 1'b1;
                     latest_in               = push_slot;
                  end
                  ACT_TICK: state_in = ST_TICK;
                  ACT_READ: begin
                     state_in     = ST_READ;
                     win_fresh_in = 1'b0;
                     buttons_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            if (age_below) begin
               slot_age_in[idx_ff] = age_inc;
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (fresh_now) begin
               buttons_in = buttons_ff | slot_buttons_ff[idx_ff];
            end
            if (idx_ff == latest_ff) begin
               win_fresh_in    = fresh_now;
               win_steer_in    = slot_steer_ff[idx_ff];
               win_throttle_in = slot_throttle_ff[idx_ff];
               win_brake_in    = slot_brake_ff[idx_ff];
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (win_fresh_ff) begin
                  rsp_data_in.steer_out      = win_steer_ff;
                  rsp_data_in.throttle_out   = win_throttle_ff;
                  rsp_data_in.brake_out      = win_brake_ff;
                  rsp_data_in.merged_buttons = buttons_ff;
                  rsp_data_in.any_fresh      = 1'b1;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_TICKS_RESET;
         fallback_ff  <= FALLBACK_RESET;
         slot_age_ff  <= '{default: '0};
         slot_seen_ff <= '0;
         latest_ff    <= '0;
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         win_fresh_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         fallback_ff  <= fallback_in;
         slot_age_ff  <= slot_age_in;
         slot_seen_ff <= slot_seen_in;
         latest_ff    <= latest_in;
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         win_fresh_ff <= win_fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: slot values, read accumulators, response data
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         slot_steer_ff[push_slot]    <= steer_c[10:0];
         slot_throttle_ff[push_slot] <= throttle_c[9:0];
         slot_brake_ff[push_slot]    <= brake_c[9:0];
         slot_buttons_ff[push_slot]  <= req_data.button_bits;
      end
      buttons_ff      <= buttons_in;
      win_steer_ff    <= win_steer_in;
      win_throttle_ff <= win_throttle_in;
      win_brake_ff    <= win_brake_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a stale response carries nothing but zeros
   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.any_fresh |->
         rsp_data_ff.steer_out == '0 && rsp_data_ff.throttle_out == '0 &&
         rsp_data_ff.brake_out == '0 && rsp_data_ff.merged_buttons == '0)
      else $error("stale response carries nonzero fields");

   // an accepted read starts its slot walk at slot 0
   a_read_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.action == ACT_READ |=> state_ff == ST_READ && idx_ff == '0)
      else $error("read did not start scan at slot 0");

   // the response register is loaded only when leaving the done state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

   // no response survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && state_ff == ST_IDLE)
      else $error("response or sequencer not cleared by reset");

endmodule

// ----- sim/tb_input_source_freshness_merger_core.sv -----
// Self-checking testbench for input_source_freshness_merger_core.
// Drives a directed table and then random control events and checks every read response
// against a bench predictor or a hand-written answer; depends on isfm_pkg and the core only.
module tb_input_source_freshness_merger_core
   import isfm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // action 3 is not decoded by the block: no state change, no response
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // idle cycles before a register write, longer than a tick or read walk
   localparam int SETTLE_CYCLES = 4 * SOURCES + 8;
   // watchdog: cycles in a row without any transfer
   localparam int QUIET_LIMIT = 1000;

   // random part: one register setting per phase
   localparam int PHASES = 8;
   localparam int PHASE_EVENTS = 178;
   localparam int unsigned HOLD_PLAN[PHASES] = '{1, 65535, 3, 0, 5, 2, 43690, 9};
   localparam int unsigned FALLBACK_PLAN[PHASES] = '{2, 3, 1, 0, 3, 1, 2, 0};

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_data;

   // directed rows with a hand-written answer ride along with the payload
   logic    req_known;
   rsp_type req_known_rsp;

   input_source_freshness_merger_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: bench copy of the slots and registers
   // ------------------------------------------------------------------
   logic signed [10:0] held_steer[SOURCES];
   logic [9:0]         held_throttle[SOURCES];
   logic [9:0]         held_brake[SOURCES];
   logic [31:0]        held_buttons[SOURCES];
   logic [15:0]        held_age[SOURCES];
   bit                 held_seen[SOURCES];
   logic [SLOT_W-1:0]  newest_slot;
   logic [15:0]        hold_limit;
   logic [1:0]         fallback_slot;

   rsp_type merged_q[$];      // expected read responses, oldest first
   int      mismatch_count = 0;
   int      quiet_cycles = 0;
   int      burst_left = 0;

   function automatic logic signed [15:0] limit_value(input logic signed [15:0] v,
                                                      input logic signed [15:0] lo,
                                                      input logic signed [15:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // fresh = pushed at least once and not yet aged out
   function automatic bit slot_fresh(input int i);
      return held_seen[i] && (held_age[i] < hold_limit);
   endfunction

   // Applies one accepted event to the bench state; a read yields a response.
   task automatic apply_control_event(input req_type r, output bit has_rsp,
                                      output rsp_type o);
      logic [SLOT_W-1:0] slot;
      logic [31:0]       ored;
      has_rsp = 1'b0;
      o = '0;
      ored = '0;
      case (r.action)
         ACT_PUSH: begin
            // bad source goes to the fallback slot, bad fallback to slot 0
            if (r.source < SOURCES) slot = SLOT_W'(r.source);
            else if (fallback_slot < SOURCES) slot = SLOT_W'(fallback_slot);
            else slot = '0;
            held_steer[slot]    = 11'(limit_value(r.steer_in, STEER_MIN, STEER_MAX));
            held_throttle[slot] = 10'(limit_value(r.throttle_in, PEDAL_MIN, PEDAL_MAX));
            held_brake[slot]    = 10'(limit_value(r.brake_in, PEDAL_MIN, PEDAL_MAX));
            held_buttons[slot]  = r.button_bits;
            held_age[slot]      = '0;
            held_seen[slot]     = 1'b1;
            newest_slot         = slot;
         end
         ACT_TICK: begin
            // ages saturate at the hold time
            for (int i = 0; i < SOURCES; i++)
               if (held_age[i] < hold_limit) held_age[i]++;
         end
         ACT_READ: begin
            has_rsp = 1'b1;
            // newest slot has the smallest age: if it is stale, so is everything
            if (slot_fresh(newest_slot)) begin
               for (int i = 0; i < SOURCES; i++)
                  if (slot_fresh(i)) ored |= held_buttons[i];
               o.steer_out      = held_steer[newest_slot];
               o.throttle_out   = held_throttle[newest_slot];
               o.brake_out      = held_brake[newest_slot];
               o.merged_buttons = ored;
               o.any_fresh      = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: register writes, request transfers, response checks.
   // Response check runs before the push so a same-edge read cannot pair
   // with its own expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit      produced;
      rsp_type predicted;
      rsp_type want;
      bit      moved;
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            held_age[i]  = '0;
            held_seen[i] = 1'b0;
         end
         newest_slot   = '0;
         hold_limit    = HOLD_TICKS_RESET;
         fallback_slot = FALLBACK_RESET;
         quiet_cycles  = 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == CSR_HOLD_TICKS) hold_limit = csr_data;
            else if (csr_index == CSR_FALLBACK) fallback_slot = csr_data[1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (merged_q.size() == 0) begin
               $display("%0t: unexpected response transfer, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = merged_q.pop_front();
               check_field("steer_out", longint'(want.steer_out),
                           longint'(rsp_data.steer_out));
               check_field("throttle_out", want.throttle_out, rsp_data.throttle_out);
               check_field("brake_out", want.brake_out, rsp_data.brake_out);
               check_field("merged_buttons", want.merged_buttons, rsp_data.merged_buttons);
               check_field("any_fresh", want.any_fresh, rsp_data.any_fresh);
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            apply_control_event(req_data, produced, predicted);
            if (produced) merged_q.push_back(req_known ? req_known_rsp : predicted);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern switches at random among four modes
   // (never, coin flip, sparse, long runs)
   // ------------------------------------------------------------------
   int stall_mode = 0;
   int stall_span = 0;
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 200);
      end
      stall_span--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ((stall_span % 32) < 24);
      endcase
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   typedef struct {
      bit          is_config;
      logic [15:0] hold;
      logic [1:0]  fallback;
      req_type     item;
      bit          known;
      rsp_type     known_rsp;
   } plan_row_type;

   plan_row_type plan_q[$];

   task automatic plan_item(input logic [1:0] act, input logic [3:0] src,
                            input logic signed [15:0] st, input logic signed [15:0] th,
                            input logic signed [15:0] br, input logic [31:0] btn);
      plan_row_type row;
      row = '{default: '0};
      row.item = '{action: act, source: src, steer_in: st, throttle_in: th,
                   brake_in: br, button_bits: btn};
      plan_q.push_back(row);
   endtask

   // read whose answer is obvious from the rows before it
   task automatic plan_read_known(input int st, input int th, input int br,
                                  input logic [31:0] btn, input bit fresh);
      plan_row_type row;
      row = '{default: '0};
      row.item.action = ACT_READ;
      row.known = 1'b1;
      row.known_rsp = '{steer_out: 11'(st), throttle_out: 10'(th), brake_out: 10'(br),
                        merged_buttons: btn, any_fresh: fresh};
      plan_q.push_back(row);
   endtask

   task automatic plan_config(input logic [15:0] hold, input logic [1:0] fb);
      plan_row_type row;
      row = '{default: '0};
      row.is_config = 1'b1;
      row.hold = hold;
      row.fallback = fb;
      plan_q.push_back(row);
   endtask

   // Present one request and hold it until the transfer happens.
   task automatic send_request(input req_type r, input bit known, input rsp_type kr);
      req_data      <= r;
      req_known     <= known;
      req_known_rsp <= kr;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Sender pacing: bursts of random length, random gaps, some back-to-back runs.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain: wait until the last request transfer is logged and every response is in,
   // then idle for SETTLE_CYCLES so a trailing tick walk can finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (merged_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back, only with the block idle.
   task automatic configure(input logic [15:0] hold, input logic [1:0] fb);
      settle();
      csr_index <= CSR_HOLD_TICKS;
      csr_data  <= hold;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FALLBACK;
      csr_data  <= {14'd0, fb};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_analog();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = int'($urandom_range(0, 2000)) - 1000;
         2: v = (int'($urandom_range(0, 2)) - 1) * 1000 + int'($urandom_range(0, 2)) - 1;
         3: v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return 16'(v);
   endfunction

   function automatic req_type random_event();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) r.action = ACT_PUSH;
      else if (pick < 72) r.action = ACT_READ;
      else if (pick < 95) r.action = ACT_TICK;
      else r.action = ACT_UNUSED;
      // mostly real slots, some out-of-range sources to hit the fallback
      if ($urandom_range(0, 6) == 0) r.source = 4'($urandom_range(SOURCES, 15));
      else r.source = 4'($urandom_range(0, SOURCES - 1));
      r.steer_in    = random_analog();
      r.throttle_in = random_analog();
      r.brake_in    = random_analog();
      r.button_bits = $urandom();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Watchdog: nothing moving for too long ends the run
   // ------------------------------------------------------------------
   initial begin
      @(negedge reset);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_type r;
      int      counted;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      req_known     <= 1'b0;
      req_known_rsp <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_HOLD_TICKS;
      csr_data      <= '0;

      // Directed table, reset registers first (hold 3000, fallback slot 0).
      // nothing pushed yet: read sees no fresh slot
      plan_read_known(0, 0, 0, 32'h0, 1'b0);
      // most negative raw values clamp to -1000 / 0 / 0
      plan_item(ACT_PUSH, 4'd0, -16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
      plan_read_known(-1000, 0, 0, 32'hFFFF_FFFF, 1'b1);
      // most positive raw values clamp to 1000
      plan_item(ACT_PUSH, 4'd1, 16'sd32767, 16'sd32767, 16'sd32767, 32'h0000_0001);
      plan_read_known(1000, 1000, 1000, 32'hFFFF_FFFF, 1'b1);
      // source 15 is out of range: lands in fallback slot 0
      plan_item(ACT_PUSH, 4'd15, 16'sd1000, 16'sd1000, 16'sd0, 32'h8000_0000);
      plan_read_known(1000, 1000, 0, 32'h8000_0001, 1'b1);
      // one past each clamp edge
      plan_item(ACT_PUSH, 4'd3, -16'sd1001, -16'sd1, 16'sd1001, 32'h0000_5A00);
      plan_item(ACT_READ, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_TICK, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      // unused action: no response, no state change
      plan_item(ACT_UNUSED, 4'd7, 16'sd123, -16'sd5, 16'sd77, 32'hDEAD_BEEF);
      plan_item(ACT_READ, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_PUSH, 4'd2, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_READ, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      // short hold, fallback to the last slot
      plan_config(16'd2, 2'd3);
      plan_item(ACT_PUSH, 4'd4, 16'sd500, 16'sd250, 16'sd750, 32'h0F0F_0000);
      plan_item(ACT_TICK, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_READ, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_TICK, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      // every slot aged to the hold time: all stale
      plan_read_known(0, 0, 0, 32'h0, 1'b0);
      // extra tick on saturated ages
      plan_item(ACT_TICK, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      plan_item(ACT_PUSH, 4'd1, -16'sd300, 16'sd999, 16'sd1, 32'h1234_5678);
      plan_item(ACT_READ, 4'd0, 16'sd0, 16'sd0, 16'sd0, 32'h0);
      // zero hold: nothing is ever fresh, even right after a push
      plan_config(16'd0, 2'd0);
      plan_item(ACT_PUSH, 4'd0, 16'sd10, 16'sd20, 16'sd30, 32'hFFFF_0000);
      plan_read_known(0, 0, 0, 32'h0, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_q[k]) begin
         if (plan_q[k].is_config) begin
            configure(plan_q[k].hold, plan_q[k].fallback);
         end else begin
            send_request(plan_q[k].item, plan_q[k].known, plan_q[k].known_rsp);
            pace();
         end
      end

      // Random phases, one register setting each; extremes of hold included.
      for (int p = 0; p < PHASES; p++) begin
         configure(16'(HOLD_PLAN[p]), 2'(FALLBACK_PLAN[p]));
         counted = 0;
         while (counted < PHASE_EVENTS) begin
            r = random_event();
            send_request(r, 1'b0, '0);
            pace();
            if (r.action != ACT_UNUSED) counted++;
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
